// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Assertion helpers shared by the RTL of the page replacement block.
// ----------------------------------------------------------------------------
// Every check runs on the rising edge of clock and is muted while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check of a property.
`define SCPR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies a property in the same cycle.
`define SCPR_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Check that a condition implies a property in the next cycle.
`define SCPR_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/scpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Second-chance page replacement package
// Fixed widths of the configuration and counter fields, and the configuration reset value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scpr_pkg;

   localparam int CFG_W   = 5;
   localparam int TOTAL_W = 32;

   typedef logic [CFG_W-1:0]   cfg_type;
   typedef logic [TOTAL_W-1:0] total_type;

   localparam cfg_type FRAMES_RESET = cfg_type'(13);

endpackage

// ===== rtl/second_chance_page_replacement_top.sv =====
// ----------------------------------------------------------------------------
// Second-chance (clock) page replacement engine
// Each request carries one page number. The engine looks the page up among
// the resident frames, marks it referenced on a hit, and on a fault either
// fills a free frame or sweeps the clock hand to pick a victim. One response
// is returned per request with hit, eviction and saturating hit/fault totals.
// Channels: req_* accepts a request when req_valid is high and req_stall low.
// rsp_* delivers a response when rsp_valid is high and rsp_stall is low.
// csr_* writes frames_in_use (always ready); write it only while idle.
// Operation: a request holds the engine from acceptance to the next possible
// acceptance, reading one frame per cycle through the shared read port. A hit
// ends the scan at the matching frame, a fault with a free frame scans every
// frame in use and then fills the next one, and a fault with eviction scans,
// then sweeps the hand past referenced frames (at most the capacity) to a victim.
// req_stall is high while a request is in progress. A new request may be
// accepted while the previous response still waits in the output register.
// If rsp_stall holds the output, the engine waits in its reply step.
// Reset (synchronous, active high) empties all frames, clears reference
// bits, hand and totals, and sets frames_in_use to 13.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module second_chance_page_replacement_top #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // Page reference requests
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [PAGE_WIDTH-1:0]   req_page_number,
   // Responses
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_hit,
   output logic                    rsp_evicted_valid,
   output logic [PAGE_WIDTH-1:0]   rsp_evicted_page,
   output scpr_pkg::total_type     rsp_hit_total,
   output scpr_pkg::total_type     rsp_fault_total,
   // Configuration write
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  scpr_pkg::cfg_type       csr_frames_in_use
);

   import scpr_pkg::*;

   // Counters hold values up to MAX_FRAMES; frame indexes only reach MAX_FRAMES - 1.
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_FRAMES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_MISS,
      ST_SWEEP,
      ST_EVICT,
      ST_REPLY
   } state_type;

   state_type               state_ff, state_in;
   cfg_type                 cfg_ff, cfg_in;
   logic [PAGE_WIDTH-1:0]   page_ff, page_in;
   logic [CNT_W-1:0]        used_ff, used_in;
   logic [CNT_W-1:0]        scan_ff, scan_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]        hand_ff, hand_in;
   logic [CNT_W-1:0]        occ_ff, occ_in;
   logic [MAX_FRAMES-1:0]   ref_ff, ref_in;
   total_type               hit_cnt_ff, hit_cnt_in;
   total_type               fault_cnt_ff, fault_cnt_in;
   logic                    res_hit_ff, res_hit_in;
   logic                    res_ev_ff, res_ev_in;
   logic [PAGE_WIDTH-1:0]   res_page_ff, res_page_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic                    rsp_ev_ff, rsp_ev_in;
   logic [PAGE_WIDTH-1:0]   rsp_page_ff, rsp_page_in;
   total_type               rsp_hits_ff, rsp_hits_in;
   total_type               rsp_faults_ff, rsp_faults_in;

   // Frame page memory: one write and one registered read per cycle.
   logic [PAGE_WIDTH-1:0]   frame_page_mem [MAX_FRAMES];
   logic [PAGE_WIDTH-1:0]   rd_data_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;

   logic [CNT_W-1:0]        cap;
   logic [CNT_W-1:0]        hand_plus;
   logic [IDX_W-1:0]        hand_next;

   // Effective capacity: a setting of zero acts as one frame, and anything
   // above the physical frame count is clipped to it.
   assign cap = (cfg_ff == '0) ? CNT_W'(1) :
                (32'(cfg_ff) > 32'(MAX_FRAMES)) ? CAP_MAX : CNT_W'(cfg_ff);

   // The hand advances in index order and wraps at the capacity.
   assign hand_plus = CNT_W'(hand_ff) + CNT_W'(1);
   assign hand_next = (hand_plus >= cap) ? '0 : hand_plus[IDX_W-1:0];

   assign req_stall         = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_page  = rsp_page_ff;
   assign rsp_hit_total     = rsp_hits_ff;
   assign rsp_fault_total   = rsp_faults_ff;

   always_comb begin
      state_in      = state_ff;
      cfg_in        = cfg_ff;
      page_in       = page_ff;
      used_in       = used_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      hand_in       = hand_ff;
      occ_in        = occ_ff;
      ref_in        = ref_ff;
      hit_cnt_in    = hit_cnt_ff;
      fault_cnt_in  = fault_cnt_ff;
      res_hit_in    = res_hit_ff;
      res_ev_in     = res_ev_ff;
      res_page_in   = res_page_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_hit_in    = rsp_hit_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_hits_in   = rsp_hits_ff;
      rsp_faults_in = rsp_faults_ff;
      rd_addr       = hand_ff;
      wr_en         = 1'b0;
      wr_addr       = hand_ff;

      if (csr_valid) begin
         cfg_in = csr_frames_in_use;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               page_in    = req_page_number;
               // Frames at or above the capacity are not resident.
               used_in    = (occ_ff < cap) ? occ_ff : cap;
               scan_in    = '0;
               cmp_vld_in = 1'b0;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // Reads are issued one frame per cycle; each compare uses the registered read data.
            rd_addr = scan_ff[IDX_W-1:0];
            if (cmp_vld_ff && (rd_data_ff == page_ff)) begin
               ref_in[cmp_idx_ff] = 1'b1;
               res_hit_in  = 1'b1;
               res_ev_in   = 1'b0;
               res_page_in = '0;
               cmp_vld_in  = 1'b0;
               if (hit_cnt_ff != '1) begin
                  hit_cnt_in = hit_cnt_ff + total_type'(1);
               end
               state_in = ST_REPLY;
            end else if (scan_ff < used_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end else if (!cmp_vld_ff) begin
               state_in = ST_MISS;
            end else begin
               cmp_vld_in = 1'b0;
            end
         end
         ST_MISS: begin
            res_hit_in = 1'b0;
            if (fault_cnt_ff != '1) begin
               fault_cnt_in = fault_cnt_ff + total_type'(1);
            end
            if (used_ff < cap) begin
               wr_en                       = 1'b1;
               wr_addr                     = used_ff[IDX_W-1:0];
               ref_in[used_ff[IDX_W-1:0]]  = 1'b0;
               occ_in                      = used_ff + CNT_W'(1);
               res_ev_in                   = 1'b0;
               res_page_in                 = '0;
               state_in                    = ST_REPLY;
            end else begin
               hand_in  = (CNT_W'(hand_ff) < cap) ? hand_ff : '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            rd_addr = hand_ff;
            if (ref_ff[hand_ff]) begin
               ref_in[hand_ff] = 1'b0;
               hand_in         = hand_next;
            end else begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            res_ev_in       = 1'b1;
            res_page_in     = rd_data_ff;
            wr_en           = 1'b1;
            wr_addr         = hand_ff;
            ref_in[hand_ff] = 1'b0;
            hand_in         = hand_next;
            occ_in          = cap;
            state_in        = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = res_hit_ff;
               rsp_ev_in     = res_ev_ff;
               rsp_page_in   = res_page_ff;
               rsp_hits_in   = hit_cnt_ff;
               rsp_faults_in = fault_cnt_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= FRAMES_RESET;
         cmp_vld_ff   <= 1'b0;
         hand_ff      <= '0;
         occ_ff       <= '0;
         ref_ff       <= '0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         cmp_vld_ff   <= cmp_vld_in;
         hand_ff      <= hand_in;
         occ_ff       <= occ_in;
         ref_ff       <= ref_in;
         hit_cnt_ff   <= hit_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      page_ff       <= page_in;
      used_ff       <= used_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_hit_ff    <= res_hit_in;
      res_ev_ff     <= res_ev_in;
      res_page_ff   <= res_page_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_hits_ff   <= rsp_hits_in;
      rsp_faults_ff <= rsp_faults_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_page_mem[wr_addr] <= page_ff;
      end
      rd_data_ff <= frame_page_mem[rd_addr];
   end

   `SCPR_ASSERT_NEXT(a_accept_lookup, req_valid && !req_stall, state_ff == ST_LOOKUP, "no lookup")
   `SCPR_ASSERT_IMPL(a_used_cap, state_ff == ST_LOOKUP, used_ff <= cap, "lookup beyond capacity")
   `SCPR_ASSERT_IMPL(a_hand_cap, state_ff == ST_SWEEP, CNT_W'(hand_ff) < cap, "bad hand")
   `SCPR_ASSERT_NEXT(a_evict_full, state_ff == ST_EVICT, occ_ff == cap, "not full after evict")
   `SCPR_ASSERT(a_hit_no_evict, !(rsp_valid_ff && rsp_hit_ff && rsp_ev_ff), "hit with eviction")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the second-chance page replacement engine
// Sends page references through the request channel and checks every response
// against an in-bench clock-algorithm predictor. The run starts with short
// directed sequences and then moves through several frame settings with
// randomized sender gaps and receiver stalls. It also includes one long
// receiver hold-off that backs the engine up.
// ----------------------------------------------------------------------------

module testbench;
   import scpr_pkg::*;

   localparam int PAGE_W      = 16;
   localparam int FRAME_SLOTS = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int REPORT_MAX  = 10;

   // One expected response, field for field as the response channel carries it.
   typedef struct packed {
      logic              hit;
      logic              ev_valid;
      logic [PAGE_W-1:0] ev_page;
      total_type         hit_total;
      total_type         fault_total;
   } page_outcome_type;

   // Block inputs are given known values from time zero.
   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_stall;
   logic [PAGE_W-1:0] req_page_number   = '0;
   logic              rsp_valid;
   logic              rsp_stall         = 1'b0;
   logic              rsp_hit;
   logic              rsp_evicted_valid;
   logic [PAGE_W-1:0] rsp_evicted_page;
   total_type         rsp_hit_total;
   total_type         rsp_fault_total;
   logic              csr_valid         = 1'b0;
   logic              csr_ready;
   cfg_type           csr_frames_in_use = '0;

   // Requests waiting to be offered, and responses the predictor has produced.
   logic [PAGE_W-1:0] pending_pages[$];
   page_outcome_type  expected_outcomes[$];
   page_outcome_type  front_outcome;

   // Predictor state: the frames, their reference bits, occupancy, hand and totals.
   logic [PAGE_W-1:0] slot_page [FRAME_SLOTS];
   bit                slot_ref  [FRAME_SLOTS];
   int unsigned       slots_filled   = 0;
   int unsigned       sweep_hand     = 0;
   total_type         hits_so_far    = '0;
   total_type         faults_so_far  = '0;
   cfg_type           frames_setting = FRAMES_RESET;

   // Traffic shaping for the current phase, in percent of cycles.
   int unsigned       send_idle_pct = 0;
   int unsigned       stall_pct     = 0;
   logic              hold_arm      = 1'b0;
   int unsigned       hold_left     = 0;

   int unsigned       mismatch_count = 0;
   int unsigned       resp_seen      = 0;

   second_chance_page_replacement_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_fault_total   (rsp_fault_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use)
   );

   always #5 clock = ~clock;

   // The frame setting is clamped: zero behaves as one frame, and anything
   // above the number of physical frames behaves as all of them.
   function automatic int unsigned frame_limit();
      int unsigned cap;
      cap = frames_setting;
      if (cap < 1) cap = 1;
      if (cap > FRAME_SLOTS) cap = FRAME_SLOTS;
      return cap;
   endfunction

   // Applies one page reference to the predictor and returns the response the
   // engine must produce for it.
   function automatic page_outcome_type apply_reference(input logic [PAGE_W-1:0] page);
      page_outcome_type res;
      int unsigned   cap;
      int unsigned   used;
      int unsigned   h;
      int unsigned   steps;
      int            found;
      cap   = frame_limit();
      // Frames at or above a lowered capacity are no longer resident.
      used  = (slots_filled < cap) ? slots_filled : cap;
      res   = '0;
      found = -1;
      for (int i = 0; i < used; i++) begin
         if (found < 0 && slot_page[i] == page) found = i;
      end
      if (found >= 0) begin
         slot_ref[found] = 1'b1;
         res.hit = 1'b1;
         if (hits_so_far != '1) hits_so_far++;
      end else begin
         if (faults_so_far != '1) faults_so_far++;
         if (used < cap) begin
            // A free frame is left, so the page goes into the next one.
            slot_page[used] = page;
            slot_ref[used]  = 1'b0;
            slots_filled    = used + 1;
         end else begin
            // Memory is full. The hand sweeps from its position and restarts
            // at zero if a lowered capacity left it out of range. Referenced
            // frames get their bit cleared and are passed over.
            h = (sweep_hand < cap) ? sweep_hand : 0;
            for (steps = 0; steps < 2 * cap && slot_ref[h]; steps++) begin
               slot_ref[h] = 1'b0;
               h = (h + 1) % cap;
            end
            res.ev_valid = 1'b1;
            res.ev_page  = slot_page[h];
            slot_page[h] = page;
            slot_ref[h]  = 1'b0;
            sweep_hand   = (h + 1) % cap;
            slots_filled = cap;
         end
      end
      res.hit_total   = hits_so_far;
      res.fault_total = faults_so_far;
      return res;
   endfunction

   // Request driver. The valid is raised from the pending queue unless the
   // phase asks for a gap. A stalled request is held unchanged. The predictor
   // runs on the edge that accepts the request.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_outcomes = {expected_outcomes, apply_reference(req_page_number)};
         end
         if (pending_pages.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid       <= 1'b1;
            req_page_number <= pending_pages[0];
            pending_pages.delete(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long hold-off on the response side. Once it is armed, the receiver stays
   // stalled until hold_left counts down to zero, while the driver keeps offering
   // requests. During that time the engine fills up and raises req_stall.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm) begin
         hold_left <= HOLD_CYCLES;
      end
   end

   // Response receiver: random stalls at the phase rate, plus the hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic note_mismatch(input string field_name, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("response %0d: %s expected %0h, got %0h", resp_seen, field_name, want, got);
   endtask

   // Response monitor. Each accepted response is checked against the oldest
   // prediction. A response that arrives with nothing predicted counts as a
   // failure too.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            note_mismatch("unexpected response, hit", 32'(0), 32'(rsp_hit));
         end else begin
            front_outcome = expected_outcomes[0];
            expected_outcomes.delete(0);
            if (rsp_hit !== front_outcome.hit)
               note_mismatch("hit", 32'(front_outcome.hit), 32'(rsp_hit));
            if (rsp_evicted_valid !== front_outcome.ev_valid)
               note_mismatch("evicted_valid", 32'(front_outcome.ev_valid),
                             32'(rsp_evicted_valid));
            // Without an eviction the evicted page reads as zero.
            if (rsp_evicted_page !== front_outcome.ev_page)
               note_mismatch("evicted_page", 32'(front_outcome.ev_page),
                             32'(rsp_evicted_page));
            if (rsp_hit_total !== front_outcome.hit_total)
               note_mismatch("hit_total", front_outcome.hit_total, rsp_hit_total);
            if (rsp_fault_total !== front_outcome.fault_total)
               note_mismatch("fault_total", front_outcome.fault_total, rsp_fault_total);
         end
         resp_seen++;
      end
   end

   // Waits until every request has been sent and answered. The check is made
   // on the falling edge, so it never races the clocked processes.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_pages.size() != 0 || req_valid || expected_outcomes.size() != 0);
   endtask

   // Writes the frame setting while the engine is idle. The task returns on a
   // falling edge, so any queue filling that follows is settled before the
   // driver looks at the queue.
   task automatic write_frames(input cfg_type value);
      @(posedge clock);
      csr_valid         <= 1'b1;
      csr_frames_in_use <= value;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      csr_valid      <= 1'b0;
      frames_setting  = value;
      @(negedge clock);
   endtask

   // Queues random references. Most fall in a window a little wider than the
   // capacity, which gives a mix of hits, fills and sweeps. The window moves
   // now and then, and a share of the pages is drawn from the whole range.
   task automatic queue_random(input int count);
      int unsigned span;
      int unsigned base;
      int unsigned r;
      span = frame_limit() + 1 + $urandom_range(0, 3);
      base = $urandom_range(0, 65535);
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 49) == 0) base = $urandom_range(0, 65535);
         if (r < 85) begin
            pending_pages = {pending_pages, PAGE_W'(base + $urandom_range(0, span - 1))};
         end else begin
            pending_pages = {pending_pages, PAGE_W'($urandom_range(0, 65535))};
         end
      end
   endtask

   // Frame settings for the random segments. They include lowering below the
   // current occupancy, raising while full, zero, and values above the frame
   // count. The sender and receiver idle rates change every two segments.
   cfg_type     cfg_plan   [8] = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd9, 5'd0, 5'd2, 5'd12};
   int unsigned idle_plan  [4] = '{0, 51, 0, 17};
   int unsigned stall_plan [4] = '{0, 0, 51, 17};

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, first at the reset setting of thirteen frames. It covers
      // the lowest and highest pages, alternating bit patterns, and a
      // reference to the same page again.
      pending_pages = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555};
      wait_drained();

      // A single frame: repeated pages hit, and every new page evicts.
      write_frames(cfg_type'(1));
      pending_pages = '{16'h0007, 16'h0007, 16'h0008, 16'h0008, 16'h0009};
      wait_drained();

      // A setting of zero must behave like a single frame.
      write_frames(cfg_type'(0));
      pending_pages = '{16'h0003, 16'h0003, 16'h0004};
      wait_drained();

      // Three frames. The hand skips a referenced frame and clears its bit,
      // and a later sweep wraps around past the end.
      write_frames(cfg_type'(3));
      pending_pages = '{16'h0001, 16'h0002, 16'h0004, 16'h0005, 16'h0002, 16'h0006};
      wait_drained();

      // A value above the frame count gives all frames. Raising the capacity
      // while full makes the next faults fill new frames.
      write_frames(cfg_type'(31));
      pending_pages = '{16'h000A, 16'h000B, 16'h000C};
      wait_drained();

      // Lowering below the occupancy hides the upper frames from the lookup,
      // so a page held in a frame above the new capacity faults again.
      write_frames(cfg_type'(2));
      pending_pages = '{16'h0005, 16'h000A};

      for (int seg = 0; seg < 8; seg++) begin
         wait_drained();
         send_idle_pct = idle_plan[seg / 2];
         stall_pct     = stall_plan[seg / 2];
         write_frames(cfg_plan[seg]);
         queue_random(170);
         if (seg == 0) begin
            // Arm the long receiver hold-off while requests keep flowing.
            @(posedge clock);
            hold_arm <= 1'b1;
            @(posedge clock);
            hold_arm <= 1'b0;
         end
      end

      wait_drained();
      // Give a stray extra response time to show up before the verdict.
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // Watchdog. The normal run takes well under a fifth of this time.
   initial begin
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/scpr_pkg.sv
rtl/second_chance_page_replacement_top.sv
tb/sv/testbench.sv
